### hw/rtl/rmir_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rmir_pkg;

  localparam int VALUE_W         = 32;
  localparam int MEDIAN_W        = 33;
  localparam int STATUS_W        = 2;
  localparam int STORE_DEPTH_DEF = 1024;

  // operation codes carried in tuser
  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_WRONG = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef logic signed [VALUE_W-1:0] value_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic   update;
    logic   remove;
    value_t value;
  } cell_ctrl_t;

  // one node of the reduction tree: match flag and the two middle keys
  typedef struct packed {
    logic   found;
    value_t lo;
    value_t hi;
  } node_t;

endpackage
`default_nettype wire

### hw/rtl/rmir_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module rmir_cell #(
  parameter int IW    = 10,
  parameter int CW    = 11,
  parameter int INDEX = 0
) (
  input  logic                 clk,
  input  rmir_pkg::cell_ctrl_t ctrl,
  input  logic [CW-1:0]        count,
  input  logic [IW-1:0]        mid_lo,
  input  logic [IW-1:0]        mid_hi,
  input  rmir_pkg::value_t     left_key,
  input  logic                 left_le,
  input  rmir_pkg::value_t     right_key,
  output rmir_pkg::value_t     key,
  output logic                 le,
  output rmir_pkg::node_t      leaf
);

  localparam logic [CW-1:0] IDX_C = CW'(INDEX);
  localparam logic [IW-1:0] IDX_I = IW'(INDEX);

  logic occ;
  logic ge;
  logic in_range;

  assign occ      = IDX_C < count;
  assign in_range = IDX_C <= count;
  assign le       = occ && (key <= ctrl.value);
  assign ge       = occ && (key >= ctrl.value);

  assign leaf.found = occ && (key == ctrl.value);
  assign leaf.lo    = (IDX_I == mid_lo) ? key : '0;
  assign leaf.hi    = (IDX_I == mid_hi) ? key : '0;

  // insert: cells above the new value move up one place
  // remove: cells from the match on take their right neighbor
  always_ff @(posedge clk) begin
    if (ctrl.update) begin
      if (ctrl.remove) begin
        if (ge) begin
          key <= right_key;
        end
      end else if (in_range && !le) begin
        key <= left_le ? ctrl.value : left_key;
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/rmir_or_tree.sv
`timescale 1ns / 1ps
`default_nettype none
module rmir_or_tree #(
  parameter int N = 2
) (
  input  logic            clk,
  input  rmir_pkg::node_t leaf [N],
  output rmir_pkg::node_t root
);

  localparam int LEVELS = $clog2(N);
  localparam int P      = 1 << LEVELS;

  rmir_pkg::node_t pad  [P];
  rmir_pkg::node_t node [1:P-1];

  for (genvar i = 0; i < P; i++) begin : g_leaf
    if (i < N) begin : g_used
      assign pad[i] = leaf[i];
    end else begin : g_pad
      assign pad[i] = '0;
    end
  end

  // one register per node
  for (genvar k = 1; k < P; k++) begin : g_node
    if (2 * k >= P) begin : g_bottom
      always_ff @(posedge clk) begin
        node[k] <= pad[2*k-P] | pad[2*k+1-P];
      end
    end else begin : g_inner
      always_ff @(posedge clk) begin
        node[k] <= node[2*k] | node[2*k+1];
      end
    end
  end

  assign root = node[1];

endmodule
`default_nettype wire

### hw/rtl/running_median_insert_remove.sv
`timescale 1ns / 1ps
`default_nettype none
// running median of a sorted multiset of signed 32-bit values. each input word adds
// (tuser 0) or removes one occurrence of (tuser 1) the value in tdata, and gives one
// output word: twice the median (sum of the two middle entries) with status ok, or
// status wrong (remove from an empty set, no match, or set emptied) or full (add
// dropped), both with a zero median. the values sit in a row of STORE_DEPTH cells kept
// in ascending order; an update shifts the affected cells at once by one place. a registered
// or-tree over the cells, log2(STORE_DEPTH) levels deep, finds a match for a remove and
// picks out the middle entries. one word at a time: an add passes update and read, a
// remove find, update and read (no read if it empties the set), find and read waiting for
// the tree; error results for an empty or full set go from accept straight to done. the
// result register lets the next word be accepted while a result waits to be taken.
module running_median_insert_remove #(
  parameter int STORE_DEPTH = rmir_pkg::STORE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic [0:0]  s_tuser,   // [0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [32:0] median_twice, zero fill above
  output logic [1:0]  m_tuser    // [1:0] status
);

  localparam int IW       = $clog2(STORE_DEPTH);
  localparam int CW       = $clog2(STORE_DEPTH + 1);
  localparam int TREE_LAT = $clog2(STORE_DEPTH);
  localparam int LW       = $clog2(TREE_LAT + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_UPDATE,
    ST_READ,
    ST_DONE
  } state_t;

  state_t                          state;
  logic [CW-1:0]                   count;
  logic [LW-1:0]                   lat_cnt;
  rmir_pkg::value_t                value;
  logic                            remove;
  logic signed [rmir_pkg::MEDIAN_W-1:0] res_median;
  logic [rmir_pkg::STATUS_W-1:0]   res_status;

  logic [CW-1:0]        count_dec;
  logic [IW-1:0]        mid_lo;
  logic [IW-1:0]        mid_hi;
  rmir_pkg::cell_ctrl_t ctrl;
  rmir_pkg::node_t      root;
  logic                 out_free;
  logic                 tree_ready;

  rmir_pkg::value_t cell_key [STORE_DEPTH];
  logic             cell_le  [STORE_DEPTH];
  rmir_pkg::value_t lk       [STORE_DEPTH];
  logic             ll       [STORE_DEPTH];
  rmir_pkg::value_t rk       [STORE_DEPTH];
  rmir_pkg::node_t  leaf     [STORE_DEPTH];

  assign s_tready   = (state == ST_IDLE);
  assign out_free   = !m_tvalid || m_tready;
  assign tree_ready = (lat_cnt == LW'(TREE_LAT));

  // middle entries: equal for an odd count, adjacent for an even one
  assign count_dec = count - CW'(1);
  assign mid_hi    = IW'(count >> 1);
  assign mid_lo    = IW'(count_dec >> 1);

  assign ctrl.update = (state == ST_UPDATE);
  assign ctrl.remove = remove;
  assign ctrl.value  = value;

  // neighbor links; the cell below the first sees minus infinity
  for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_link
    if (i == 0) begin : g_first
      assign lk[i] = '0;
      assign ll[i] = 1'b1;
    end else begin : g_mid
      assign lk[i] = cell_key[i-1];
      assign ll[i] = cell_le[i-1];
    end
    if (i == STORE_DEPTH - 1) begin : g_last
      assign rk[i] = '0;
    end else begin : g_next
      assign rk[i] = cell_key[i+1];
    end

    rmir_cell #(
      .IW    (IW),
      .CW    (CW),
      .INDEX (i)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .count     (count),
      .mid_lo    (mid_lo),
      .mid_hi    (mid_hi),
      .left_key  (lk[i]),
      .left_le   (ll[i]),
      .right_key (rk[i]),
      .key       (cell_key[i]),
      .le        (cell_le[i]),
      .leaf      (leaf[i])
    );
  end

  rmir_or_tree #(
    .N (STORE_DEPTH)
  ) u_tree (
    .clk  (clk),
    .leaf (leaf),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      lat_cnt  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // a word taken in the done step is refilled there instead
      if (m_tvalid && m_tready && state != ST_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            value   <= s_tdata;
            remove  <= (s_tuser[0] == rmir_pkg::OP_REMOVE);
            lat_cnt <= '0;
            if (s_tuser[0] == rmir_pkg::OP_REMOVE) begin
              if (count == '0) begin
                res_median <= '0;
                res_status <= rmir_pkg::STATUS_WRONG;
                state      <= ST_DONE;
              end else begin
                state <= ST_FIND;
              end
            end else if (count == CW'(STORE_DEPTH)) begin
              res_median <= '0;
              res_status <= rmir_pkg::STATUS_FULL;
              state      <= ST_DONE;
            end else begin
              state <= ST_UPDATE;
            end
          end
        end
        ST_FIND: begin
          // wait for the match flag to reach the root
          if (tree_ready) begin
            if (root.found) begin
              state <= ST_UPDATE;
            end else begin
              res_median <= '0;
              res_status <= rmir_pkg::STATUS_WRONG;
              state      <= ST_DONE;
            end
          end else begin
            lat_cnt <= lat_cnt + LW'(1);
          end
        end
        ST_UPDATE: begin
          lat_cnt <= '0;
          if (remove) begin
            count <= count_dec;
            if (count == CW'(1)) begin
              res_median <= '0;
              res_status <= rmir_pkg::STATUS_WRONG;
              state      <= ST_DONE;
            end else begin
              state <= ST_READ;
            end
          end else begin
            count <= count + CW'(1);
            state <= ST_READ;
          end
        end
        ST_READ: begin
          if (tree_ready) begin
            res_median <= {root.lo[rmir_pkg::VALUE_W-1], root.lo}
                        + {root.hi[rmir_pkg::VALUE_W-1], root.hi};
            res_status <= rmir_pkg::STATUS_OK;
            state      <= ST_DONE;
          end else begin
            lat_cnt <= lat_cnt + LW'(1);
          end
        end
        ST_DONE: begin
          // hand over once the result register is free
          if (out_free) begin
            m_tdata  <= {7'd0, res_median};
            m_tuser  <= res_status;
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // one word in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while a word is in progress");

  // the entry count only moves in the update step
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (state != ST_UPDATE) |=> (count == $past(count)))
    else $error("entry count changed outside update");

  // an add in the update step grows the set by one
  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE && !remove) |=> (count == $past(count) + CW'(1)))
    else $error("add did not grow the entry count");

  // error results carry a zero median
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != rmir_pkg::STATUS_OK) |-> (m_tdata == '0))
    else $error("nonzero median on an error result");

  // the count never passes the store depth
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE && !remove) |-> (count != CW'(STORE_DEPTH)))
    else $error("add into a full store reached update");

endmodule
`default_nettype wire

### tb/running_median_insert_remove_test.sv
`timescale 1ns / 1ps
module running_median_insert_remove_test;
  import rmir_pkg::*;

  localparam int STORE_DEPTH     = STORE_DEPTH_DEF;
  localparam int DIRECTED_ROWS   = 25;
  localparam int MIXED_WORDS     = 400;
  localparam int GROW_WORDS      = 225;
  localparam int TAIL_WORDS      = 200;
  localparam int HOLD_AT_RESULT  = 300;
  localparam int HOLD_CYCLES     = 400;
  localparam int SETTLE_CYCLES   = 64;
  localparam int WATCHDOG_LIMIT  = 4000;

  localparam value_t VALUE_MIN = 32'sh8000_0000;
  localparam value_t VALUE_MAX = 32'sh7FFF_FFFF;

  // twice the extremes, as they leave the block
  localparam logic [MEDIAN_W-1:0] MEDIAN_ZERO      = '0;
  localparam logic [MEDIAN_W-1:0] MEDIAN_MIN_TWICE = 33'h1_0000_0000;
  localparam logic [MEDIAN_W-1:0] MEDIAN_MAX_TWICE = 33'h0_FFFF_FFFE;

  typedef logic signed [MEDIAN_W-1:0] median_t;

  typedef struct packed {
    logic [MEDIAN_W-1:0] median_twice;
    logic [STATUS_W-1:0] status;
  } median_result_t;

  // pinned rows carry a hand-written result, the rest go through the predictor
  typedef struct packed {
    logic                op;
    value_t              value;
    logic                pinned;
    logic [MEDIAN_W-1:0] median_twice;
    logic [STATUS_W-1:0] status;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // [31:0] value
  logic [0:0]  s_tuser;   // [0] operation
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // [32:0] median_twice, zero fill above
  logic [1:0]  m_tuser;   // [1:0] status

  running_median_insert_remove #(
    .STORE_DEPTH(STORE_DEPTH)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state: the multiset in ascending order
  value_t         sorted_values[$];
  median_result_t pending_medians[$];

  int mismatches;
  int results_seen;
  int words_sent;
  int adds_sent;
  int removes_sent;
  int count_ok;
  int count_wrong;
  int count_full;
  int peak_entries;
  bit send_burst;
  bit take_burst;

  // directed walk from an empty store: extremes, duplicates, every wrong-status case
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{OP_REMOVE, 32'sd0,          1'b1, MEDIAN_ZERO,      STATUS_WRONG}, // remove, empty
    '{OP_ADD,    VALUE_MIN,       1'b1, MEDIAN_MIN_TWICE, STATUS_OK},
    '{OP_REMOVE, VALUE_MIN,       1'b1, MEDIAN_ZERO,      STATUS_WRONG}, // emptied
    '{OP_ADD,    VALUE_MAX,       1'b1, MEDIAN_MAX_TWICE, STATUS_OK},
    '{OP_ADD,    VALUE_MAX,       1'b1, MEDIAN_MAX_TWICE, STATUS_OK},
    '{OP_ADD,    VALUE_MIN,       1'b0, MEDIAN_ZERO,      STATUS_OK},
    '{OP_ADD,    VALUE_MIN,       1'b0, MEDIAN_ZERO,      STATUS_OK},
    '{OP_REMOVE, 32'sd5,          1'b1, MEDIAN_ZERO,      STATUS_WRONG}, // no match
    '{OP_REMOVE, VALUE_MAX,       1'b0, MEDIAN_ZERO,      STATUS_OK},    // odd after remove
    '{OP_ADD,    32'sd0,          1'b0, MEDIAN_ZERO,      STATUS_OK},
    '{OP_ADD,    -32'sd1,         1'b0, MEDIAN_ZERO,      STATUS_OK},
    '{OP_ADD,    32'sd1,          1'b0, MEDIAN_ZERO,      STATUS_OK},
    '{OP_ADD,    32'sd0,          1'b0, MEDIAN_ZERO,      STATUS_OK},
    '{OP_ADD,    32'sh5555_5555,  1'b0, MEDIAN_ZERO,      STATUS_OK},
    '{OP_ADD,    32'shAAAA_AAAA,  1'b0, MEDIAN_ZERO,      STATUS_OK},
    '{OP_REMOVE, 32'sd0,          1'b0, MEDIAN_ZERO,      STATUS_OK},
    '{OP_REMOVE, 32'sd0,          1'b0, MEDIAN_ZERO,      STATUS_OK},
    '{OP_REMOVE, 32'sd0,          1'b1, MEDIAN_ZERO,      STATUS_WRONG}, // duplicates gone
    '{OP_REMOVE, -32'sd1,         1'b0, MEDIAN_ZERO,      STATUS_OK},
    '{OP_REMOVE, 32'sh5555_5555,  1'b0, MEDIAN_ZERO,      STATUS_OK},
    '{OP_REMOVE, VALUE_MIN,       1'b0, MEDIAN_ZERO,      STATUS_OK},
    '{OP_REMOVE, VALUE_MIN,       1'b0, MEDIAN_ZERO,      STATUS_OK},
    '{OP_REMOVE, 32'sd1,          1'b0, MEDIAN_ZERO,      STATUS_OK},
    '{OP_REMOVE, VALUE_MAX,       1'b0, MEDIAN_ZERO,      STATUS_OK},
    '{OP_REMOVE, 32'shAAAA_AAAA,  1'b1, MEDIAN_ZERO,      STATUS_WRONG}  // emptied
  };

  // twice the median of the current store, two's complement at 33 bits
  function automatic logic [MEDIAN_W-1:0] median_of_store();
    int n;
    n = sorted_values.size();
    if (n % 2 == 1)
      return median_t'(sorted_values[n / 2]) + median_t'(sorted_values[n / 2]);
    return median_t'(sorted_values[n / 2 - 1]) + median_t'(sorted_values[n / 2]);
  endfunction

  // applies one word to the multiset and gives the result the block owes for it
  function automatic median_result_t apply_to_store(logic op, value_t value);
    median_result_t result;
    int pos;
    int n;
    result = '{median_twice: MEDIAN_ZERO, status: STATUS_WRONG};
    n = sorted_values.size();
    if (op == OP_ADD) begin
      adds_sent++;
      if (n >= STORE_DEPTH) begin
        result.status = STATUS_FULL;
      end else begin
        // new value goes after any equal entries
        pos = 0;
        while (pos < n && sorted_values[pos] <= value) pos++;
        sorted_values.insert(pos, value);
        result = '{median_twice: median_of_store(), status: STATUS_OK};
      end
    end else begin
      removes_sent++;
      pos = 0;
      while (pos < n && sorted_values[pos] != value) pos++;
      if (pos < n) begin
        sorted_values.delete(pos);
        if (sorted_values.size() != 0)
          result = '{median_twice: median_of_store(), status: STATUS_OK};
      end
    end
    if (sorted_values.size() > peak_entries) peak_entries = sorted_values.size();
    case (result.status)
      STATUS_OK:    count_ok++;
      STATUS_FULL:  count_full++;
      default:      count_wrong++;
    endcase
    return result;
  endfunction

  // full range mostly, with a share of small values for duplicates and the extremes
  function automatic value_t draw_value();
    case ($urandom_range(0, 9))
      5, 6, 7: return value_t'($urandom_range(0, 32)) - 32'sd16;
      8:       return $urandom_range(0, 1) ? VALUE_MAX : VALUE_MIN;
      9:       return $urandom_range(0, 1) ? VALUE_MAX - value_t'($urandom_range(0, 3))
                                           : VALUE_MIN + value_t'($urandom_range(0, 3));
      default: return value_t'($urandom);
    endcase
  endfunction

  function automatic int draw_gap(bit burst);
    return burst ? 0 : $urandom_range(0, 11);
  endfunction

  task automatic report_mismatch(string what, logic [39:0] expected, logic [39:0] got);
    mismatches++;
    $display("mismatch %0d at result %0d: %s expected %h got %h",
             mismatches, results_seen, what, expected, got);
  endtask

  // offers one word after a random gap and records the result owed once it is taken
  task automatic send_word(logic op, value_t value, logic pinned,
                           median_result_t pinned_result);
    int gap;
    median_result_t predicted;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = draw_gap(send_burst);
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata  = value;
    s_tuser  = op;
    do @(posedge clk); while (!s_tready);
    words_sent++;
    predicted = apply_to_store(op, value);
    pending_medians.insert(pending_medians.size(), pinned ? pinned_result : predicted);
  endtask

  // removes mostly hit a stored value, the rest miss or hit by chance
  task automatic send_random_word(int add_percent);
    logic   op;
    value_t value;
    op = ($urandom_range(0, 99) < add_percent) ? OP_ADD : OP_REMOVE;
    if (op == OP_REMOVE && sorted_values.size() != 0 && $urandom_range(0, 3) != 0)
      value = sorted_values[$urandom_range(0, sorted_values.size() - 1)];
    else
      value = draw_value();
    send_word(op, value, 1'b0, '0);
  endtask

  // stimulus and the final verdict
  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = OP_ADD;
    m_tready = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i])
      send_word(directed_rows[i].op, directed_rows[i].value, directed_rows[i].pinned,
                '{median_twice: directed_rows[i].median_twice,
                  status: directed_rows[i].status});

    // random walk around a few dozen entries
    repeat (MIXED_WORDS)
      send_random_word(sorted_values.size() < 48 ? 60 : 40);

    // grow the store well past the walk, then shrink it again
    repeat (GROW_WORDS) send_random_word(80);
    repeat (TAIL_WORDS) send_random_word(35);

    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_medians.size() != 0) @(posedge clk);
    // anything arriving now has no expectation and is flagged by the receiver
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d words (%0d adds, %0d removes), peak store %0d of %0d entries",
             words_sent, adds_sent, removes_sent, peak_entries, STORE_DEPTH);
    $display("results: %0d median, %0d wrong, %0d full; %0d mismatches",
             count_ok, count_wrong, count_full, mismatches);
    if (mismatches == 0)
      $display("running_median_insert_remove regression: pass");
    else
      $display("running_median_insert_remove regression: fail");
    $finish;
  end

  // result side: random stalls, one long hold-off so the input backs up
  initial begin
    int gap;
    median_result_t expected;
    @(negedge clk iff !rst);
    forever begin
      if ($urandom_range(0, 39) == 0) take_burst = !take_burst;
      gap = (results_seen == HOLD_AT_RESULT) ? HOLD_CYCLES : draw_gap(take_burst);
      if (gap > 0) begin
        @(negedge clk);
        m_tready = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
      results_seen++;
      if (pending_medians.size() == 0) begin
        report_mismatch("result with nothing pending", '0, {m_tdata[37:0], m_tuser});
      end else begin
        expected = pending_medians.pop_front();
        if (m_tuser !== expected.status)
          report_mismatch("status", 40'(expected.status), 40'(m_tuser));
        if (m_tdata[MEDIAN_W-1:0] !== expected.median_twice)
          report_mismatch("median_twice", 40'(expected.median_twice),
                          40'(m_tdata[MEDIAN_W-1:0]));
        if (m_tdata[39:MEDIAN_W] !== '0)
          report_mismatch("tdata fill", '0, m_tdata);
      end
    end
  end

  // watchdog: cycles with no word moving on either side
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    @(negedge clk iff !rst);
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("timeout: no word moved for %0d cycles, %0d results pending",
             WATCHDOG_LIMIT, pending_medians.size());
    $display("running_median_insert_remove regression: fail");
    $finish;
  end

endmodule
